### hw/rtl/ohtab_pkg.sv
package ohtab_pkg;

  localparam int TableSlots = 26;
  localparam int WordChars  = 19;
  localparam int IdxW       = $clog2(TableSlots);
  localparam int CntW       = $clog2(TableSlots + 2);
  localparam int WordW      = 152;

  localparam logic [7:0] CharALower = 8'd97;
  localparam logic [7:0] CharAUpper = 8'd65;
  localparam logic [7:0] CharZUpper = 8'd90;
  localparam logic [7:0] CaseOffset = 8'd32;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_FOUND     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic {
    PROBE_LINEAR    = 1'b0,
    PROBE_QUADRATIC = 1'b1
  } probe_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    idx_t addr;
  } mem_req_t;

  // Keeps the characters up to the first zero byte and clears the rest.
  function automatic word_t normalise_word(word_t w);
    word_t      r;
    logic       alive;
    logic [7:0] b;
    r     = '0;
    alive = 1'b1;
    for (int k = 0; k < WordChars; k++) begin
      b     = w[8*k +: 8];
      alive = alive & (b != 8'd0);
      if (alive) begin
        r[8*k +: 8] = b;
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/open_addressing_word_hash_table.sv
// Open-addressing hash table of 26 words of up to 19 characters, keyed on the
// first letter, with linear or quadratic probing chosen by the probe mode
// register. One beat is handled at a time: the word is trimmed on acceptance,
// the first character is folded to lower case and reduced to its home slot,
// the first read is issued, slots are probed one after another (up to 26 for
// an insert, 27 for a search) and the result register is loaded. The probe
// rate is set by the single-port slot memory, which is read once per cycle.
// A waiting result at the output holds the block in its completion state, so
// the next beat is not accepted until that result is taken.
module open_addressing_word_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [63:0] word_bytes_low_i,
  input  logic [63:0] word_bytes_mid_i,
  input  logic [23:0] word_bytes_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [4:0]  slot_index_o,
  output logic [4:0]  comparisons_o
);
  import ohtab_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_NORM  = 6'b000010,
    ST_HASH  = 6'b000100,
    ST_ISSUE = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  probe_e          mode_q;
  op_e             op_q;
  word_t           word_q;
  logic [7:0]      red_q;
  logic            neg_q;
  idx_t            pos_q;
  idx_t            step_q;
  logic [CntW-1:0] cnt_q;
  status_e         res_status_q;
  idx_t            res_slot_q;
  logic [CntW-1:0] res_cnt_q;
  logic            out_valid_q;
  logic [1:0]      out_status_q;
  logic [4:0]      out_slot_q;
  logic [4:0]      out_cnt_q;

  mem_req_t        mem_req;
  logic            rd_valid;
  word_t           rd_word;

  logic [7:0]      first_char;
  logic [7:0]      lowered;
  logic [IdxW:0]   pos_sum;
  logic [IdxW:0]   odd_sum;
  idx_t            pos_nx;
  idx_t            step_nx;
  logic [CntW-1:0] cnt_inc;
  logic            hit;
  logic            finish;
  status_e         fin_status;
  logic            fin_keep_slot;
  logic [CntW-1:0] fin_cnt;
  logic            load_out;

  ohtab_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .wr_word_i  (word_q),
    .rd_valid_o (rd_valid),
    .rd_word_o  (rd_word)
  );

  always_comb begin
    first_char = word_q[7:0];
    lowered    = first_char;
    if (first_char inside {[CharAUpper:CharZUpper]}) begin
      lowered = first_char + CaseOffset;
    end
  end

  always_comb begin
    pos_sum = {1'b0, pos_q} + {1'b0, step_q};
    if (pos_sum >= (IdxW+1)'(TableSlots)) begin
      pos_nx = IdxW'(pos_sum - (IdxW+1)'(TableSlots));
    end else begin
      pos_nx = pos_sum[IdxW-1:0];
    end
    odd_sum = {1'b0, step_q} + (IdxW+1)'(2);
    if (mode_q == PROBE_LINEAR) begin
      step_nx = step_q;
    end else if (odd_sum >= (IdxW+1)'(TableSlots)) begin
      step_nx = IdxW'(odd_sum - (IdxW+1)'(TableSlots));
    end else begin
      step_nx = odd_sum[IdxW-1:0];
    end
  end

  always_comb begin
    cnt_inc       = cnt_q + CntW'(1);
    hit           = (rd_word == word_q);
    finish        = 1'b1;
    fin_status    = STATUS_NOT_FOUND;
    fin_keep_slot = 1'b0;
    fin_cnt       = cnt_q;
    if (!rd_valid) begin
      if (op_q == OP_INSERT) begin
        fin_status    = STATUS_INSERTED;
        fin_keep_slot = 1'b1;
      end
    end else if (op_q == OP_SEARCH && hit) begin
      fin_status    = STATUS_FOUND;
      fin_keep_slot = 1'b1;
    end else if (op_q == OP_INSERT && cnt_inc == CntW'(TableSlots)) begin
      fin_status = STATUS_FULL;
      fin_cnt    = cnt_inc;
    end else if (op_q == OP_SEARCH && cnt_inc == CntW'(TableSlots + 1)) begin
      fin_cnt = cnt_inc;
    end else begin
      finish = 1'b0;
    end
  end

  always_comb begin
    mem_req = '0;
    case (state_q)
      ST_ISSUE: begin
        mem_req.rd_en = 1'b1;
        mem_req.addr  = pos_q;
      end
      ST_CHECK: begin
        if (!finish) begin
          mem_req.rd_en = 1'b1;
          mem_req.addr  = pos_nx;
        end else if (!rd_valid && op_q == OP_INSERT) begin
          mem_req.wr_en = 1'b1;
          mem_req.addr  = pos_q;
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        state_d = ST_HASH;
      end
      ST_HASH: begin
        if (red_q < 8'(TableSlots)) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (finish) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= PROBE_LINEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mode_q <= probe_e'(cfg_wdata_i);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_q   <= op_e'(operation_i);
          word_q <= normalise_word({word_bytes_high_i, word_bytes_mid_i, word_bytes_low_i});
        end
      end
      ST_NORM: begin
        if (lowered >= CharALower) begin
          red_q <= lowered - CharALower;
          neg_q <= 1'b0;
        end else begin
          red_q <= CharALower - lowered;
          neg_q <= 1'b1;
        end
      end
      ST_HASH: begin
        if (red_q >= 8'(TableSlots)) begin
          red_q <= red_q - 8'(TableSlots);
        end else begin
          if (neg_q && red_q != 8'd0) begin
            pos_q <= IdxW'(8'(TableSlots) - red_q);
          end else begin
            pos_q <= IdxW'(red_q);
          end
          step_q <= IdxW'(1);
          cnt_q  <= '0;
        end
      end
      ST_CHECK: begin
        if (finish) begin
          res_status_q <= fin_status;
          res_slot_q   <= fin_keep_slot ? pos_q : '0;
          res_cnt_q    <= fin_cnt;
        end else begin
          pos_q  <= pos_nx;
          step_q <= step_nx;
          cnt_q  <= cnt_inc;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_status_q <= res_status_q;
          out_slot_q   <= 5'(res_slot_q);
          out_cnt_q    <= 5'(res_cnt_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_index_o  = out_slot_q;
  assign comparisons_o = out_cnt_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> (cnt_q <= CntW'(TableSlots)))
    else $error("probe count beyond the table size");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE || state_q == ST_CHECK) |->
      ({1'b0, pos_q} < (IdxW+1)'(TableSlots)))
    else $error("probe position beyond the table");
  a_linear_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && mode_q == PROBE_LINEAR) |-> (step_q == IdxW'(1)))
    else $error("linear probing with a step other than one");
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result beat raised outside the completion state");
`endif

endmodule

### hw/rtl/ohtab_store.sv
module ohtab_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ohtab_pkg::mem_req_t req_i,
  input  ohtab_pkg::word_t   wr_word_i,
  output logic               rd_valid_o,
  output ohtab_pkg::word_t   rd_word_o
);
  import ohtab_pkg::*;

  word_t                 mem_q [TableSlots];
  logic [TableSlots-1:0] valid_q;
  logic                  rd_valid_q;
  word_t                 rd_word_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= wr_word_i;
    end
    if (req_i.rd_en) begin
      rd_word_q <= mem_q[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.addr];
      end
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_word_o  = rd_word_q;

`ifndef NO_ASSERTIONS
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.rd_en || req_i.wr_en) |-> ({1'b0, req_i.addr} < (IdxW+1)'(TableSlots)))
    else $error("slot address beyond the table");
  a_write_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr_en |-> !valid_q[req_i.addr])
    else $error("write to an occupied slot");
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr_en |-> !req_i.rd_en)
    else $error("read and write in the same cycle");
`endif

endmodule

### verif/open_addressing_word_hash_table_test.sv
module open_addressing_word_hash_table_test;
  import ohtab_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int SettleTicks = 40;

  typedef struct packed {
    status_e    status;
    logic [4:0] slot;
    logic [4:0] comparisons;
  } hash_outcome_t;

  typedef struct {
    op_e   op;
    word_t word;
  } word_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic [63:0] word_low = '0;
  logic [63:0] word_mid = '0;
  logic [23:0] word_high = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [4:0]  slot_index;
  logic [4:0]  comparisons;
  logic        in_taken = 1'b0;

  word_beat_t    pending_beats[$];
  hash_outcome_t outcome_q[$];
  word_t         stored_words[$];

  logic   slot_full [TableSlots];
  word_t  slot_word [TableSlots];
  probe_e mode_mirror = PROBE_LINEAR;

  int send_idle_pct = 24;
  int recv_idle_pct = 59;
  int beats_queued = 0;
  int beats_accepted = 0;
  int failures = 0;
  int cycle_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  open_addressing_word_hash_table dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (operation),
    .word_bytes_low_i (word_low),
    .word_bytes_mid_i (word_mid),
    .word_bytes_high_i(word_high),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .slot_index_o     (slot_index),
    .comparisons_o    (comparisons)
  );

  always #10 clk = ~clk;

  function automatic word_t trim_word(word_t w);
    word_t r;
    logic  live;
    r    = '0;
    live = 1'b1;
    for (int k = 0; k < WordChars; k++) begin
      if (w[8*k +: 8] == 8'd0) live = 1'b0;
      if (live) r[8*k +: 8] = w[8*k +: 8];
    end
    return r;
  endfunction

  function automatic word_t with_tail_noise(word_t w);
    word_t r;
    logic  past_end;
    r        = w;
    past_end = 1'b0;
    for (int k = 0; k < WordChars; k++) begin
      if (past_end) begin
        r[8*k +: 8] = 8'($urandom);
      end else if (r[8*k +: 8] == 8'd0) begin
        past_end = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic word_t random_word(int len, bit letters_only);
    word_t      w;
    logic [7:0] b;
    w = '0;
    for (int k = 0; k < len; k++) begin
      if (letters_only) begin
        b = (($urandom_range(1) == 1) ? CharAUpper : CharALower) + 8'($urandom_range(25));
      end else begin
        b = 8'($urandom_range(255, 1));
      end
      w[8*k +: 8] = b;
    end
    return w;
  endfunction

  function automatic word_t text_word(string s);
    word_t w;
    w = '0;
    for (int k = 0; k < s.len() && k < WordChars; k++) w[8*k +: 8] = s[k];
    return w;
  endfunction

  function automatic hash_outcome_t apply_word_op(op_e op, word_t raw);
    word_t         w;
    logic [7:0]    c;
    int            home;
    int            pos;
    int            count;
    int            i;
    logic          done;
    hash_outcome_t r;
    w     = trim_word(raw);
    c     = w[7:0];
    count = 0;
    done  = 1'b0;
    r.slot = '0;
    if (c >= CharAUpper && c <= CharZUpper) c = c + CaseOffset;
    if (c >= CharALower) begin
      home = (int'(c) - int'(CharALower)) % TableSlots;
    end else begin
      home = (TableSlots - (int'(CharALower) - int'(c)) % TableSlots) % TableSlots;
    end
    if (op == OP_INSERT) begin
      r.status = STATUS_FULL;
      for (i = 0; i < TableSlots && !done; i++) begin
        pos = (home + ((mode_mirror == PROBE_QUADRATIC) ? i * i : i)) % TableSlots;
        if (!slot_full[pos]) begin
          slot_full[pos] = 1'b1;
          slot_word[pos] = w;
          r.status       = STATUS_INSERTED;
          r.slot         = 5'(pos);
          done           = 1'b1;
        end else begin
          count++;
        end
      end
    end else begin
      r.status = STATUS_NOT_FOUND;
      i        = 0;
      while (!done) begin
        pos = (home + ((mode_mirror == PROBE_QUADRATIC) ? i * i : i)) % TableSlots;
        if (!slot_full[pos]) begin
          done = 1'b1;
        end else if (slot_word[pos] == w) begin
          r.status = STATUS_FOUND;
          r.slot   = 5'(pos);
          done     = 1'b1;
        end else begin
          count++;
          if (count > TableSlots) done = 1'b1;
          i++;
        end
      end
    end
    r.comparisons = 5'(count);
    return r;
  endfunction

  task automatic queue_beat(op_e op, word_t w);
    word_beat_t b;
    b.op   = op;
    b.word = w;
    if (op == OP_INSERT) stored_words.push_back(trim_word(w));
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic wait_drained();
    while (outcome_q.size() != 0 || beats_accepted != beats_queued) @(negedge clk);
  endtask

  task automatic set_probe_mode(probe_e m);
    cfg_we      <= 1'b1;
    cfg_wdata   <= m;
    mode_mirror = m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(int n);
    int           roll;
    logic [159:0] bits;
    word_t        w;
    for (int j = 0; j < n; j++) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        w = random_word($urandom_range(WordChars), $urandom_range(9) < 7);
        if ($urandom_range(1) == 1) w = with_tail_noise(w);
        queue_beat(OP_INSERT, w);
      end else if (roll < 7) begin
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        queue_beat(op_e'($urandom_range(1)), bits[151:0]);
      end else if (stored_words.size() != 0 && $urandom_range(99) < 60) begin
        w = stored_words[$urandom_range(stored_words.size() - 1)];
        if ($urandom_range(1) == 1) w = with_tail_noise(w);
        queue_beat(OP_SEARCH, w);
      end else begin
        w = random_word($urandom_range(WordChars), $urandom_range(9) < 7);
        if ($urandom_range(1) == 1) w = with_tail_noise(w);
        queue_beat(OP_SEARCH, w);
      end
    end
  endtask

  always @(negedge clk) begin : drive_beats
    word_beat_t beat;
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_valid || in_taken) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat = pending_beats.pop_front();
          in_valid  <= 1'b1;
          operation <= beat.op;
          word_low  <= beat.word[63:0];
          word_mid  <= beat.word[127:64];
          word_high <= beat.word[151:128];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    hash_outcome_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          $error("result beat with no expectation pending: status %0d", status);
          failures++;
        end else begin
          want = outcome_q.pop_front();
          status_seen[want.status]++;
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
          end
          if (slot_index !== want.slot) begin
            $error("slot_index: expected %0d, actual %0d", want.slot, slot_index);
            failures++;
          end
          if (comparisons !== want.comparisons) begin
            $error("comparisons: expected %0d, actual %0d", want.comparisons, comparisons);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) begin
        outcome_q.push_back(apply_word_op(op_e'(operation), {word_high, word_mid, word_low}));
        beats_accepted++;
      end
      in_taken <= in_valid && in_ready;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("open_addressing_word_hash_table regression: fail");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < TableSlots; s++) begin
      slot_full[s] = 1'b0;
      slot_word[s] = '0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_probe_mode(PROBE_LINEAR);
    queue_beat(OP_INSERT, text_word("apple"));
    queue_beat(OP_INSERT, text_word("Avocado"));
    queue_beat(OP_INSERT, text_word("apple"));
    queue_beat(OP_SEARCH, text_word("apple"));
    queue_beat(OP_SEARCH, text_word("Avocado"));
    queue_beat(OP_SEARCH, text_word("avocado"));
    queue_beat(OP_SEARCH, text_word("apricot"));
    queue_beat(OP_SEARCH, text_word("zebra"));
    queue_beat(OP_INSERT, text_word("zz"));
    queue_beat(OP_INSERT, text_word("Zed"));
    queue_beat(OP_INSERT, '0);
    queue_beat(OP_INSERT, text_word("0day"));
    queue_beat(OP_INSERT, '1);
    queue_beat(OP_INSERT, with_tail_noise(text_word("ab")));
    queue_beat(OP_SEARCH, text_word("ab"));
    queue_beat(OP_SEARCH, with_tail_noise(text_word("ab")));
    queue_beat(OP_SEARCH, '1);
    queue_beat(OP_SEARCH, '0);
    wait_drained();

    set_probe_mode(PROBE_QUADRATIC);
    queue_beat(OP_INSERT, text_word("mango"));
    queue_beat(OP_INSERT, text_word("Melon"));
    queue_beat(OP_INSERT, text_word("mint"));
    queue_beat(OP_INSERT, text_word("mace"));
    queue_beat(OP_INSERT, text_word("moss"));
    queue_beat(OP_SEARCH, text_word("moss"));
    queue_beat(OP_SEARCH, text_word("mole"));
    wait_drained();

    for (int stage = 0; stage < 3; stage++) begin
      send_idle_pct = (stage == 0) ? 24 : (stage == 1) ? 59 : 0;
      recv_idle_pct = (stage == 0) ? 59 : (stage == 1) ? 24 : 0;
      for (int m = 0; m < 2; m++) begin
        set_probe_mode(probe_e'(m));
        queue_random(104);
        wait_drained();
        queue_random(104);
        wait_drained();
      end
    end

    repeat (SettleTicks) @(negedge clk);
    $display("Ran %0d beats through linear and quadratic probing under three idle patterns.",
             beats_accepted);
    $display("Results: %0d inserted, %0d full, %0d found, %0d not found.",
             status_seen[STATUS_INSERTED], status_seen[STATUS_FULL],
             status_seen[STATUS_FOUND], status_seen[STATUS_NOT_FOUND]);
    if (failures == 0 && outcome_q.size() == 0) begin
      $display("open_addressing_word_hash_table regression: pass");
    end else begin
      $display("open_addressing_word_hash_table regression: fail");
    end
    $finish;
  end

endmodule
